// File: design/tksel_pkg.sv
// ----------------------------------------------------------------------------
// tksel_pkg
// Shared widths, register codes and the per-cell control struct for the
// top-K similarity selector.
// ----------------------------------------------------------------------------
`default_nettype none

package tksel_pkg;

	// payload widths
	localparam int ID_W     = 64;
	localparam int SCORE_W  = 16;
	localparam int RANK_W   = 4;
	localparam int S_DATA_W = 80;   // node_id, score
	localparam int M_DATA_W = 88;   // rank, best_id, best_score, zero pad

	// list depth default
	localparam int K_MAX_DEF = 16;

	// configuration
	localparam int              KEEP_W     = 5;
	localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;
	localparam int              ADDR_W     = 3;
	localparam int              CFG_DATA_W = 32;

	// register index, taken from paddr[2]
	localparam logic REG_KEEP_COUNT = 1'b0;

	// broadcast control to every cell of the chain
	typedef struct packed {
		logic ins_en;   // insert the incoming candidate
		logic rot_en;   // rotate the list up by one for readout
	} cell_ctrl_t;

endpackage

`default_nettype wire

// File: design/top_k_similarity_select_top.sv
// ----------------------------------------------------------------------------
// top_k_similarity_select_top
// Keeps the best keep_count candidates in a chain of compare-and-shift cells
// and reads them out in rank order on request.
// ----------------------------------------------------------------------------
// Usage:
//  Slave stream carries one candidate per beat: tdata = {score, node_id},
//  tuser = first (empties the list first), tlast = final request.
//  Candidates stream back to back.
//  A beat with tlast starts a readout of every kept entry on the master
//  stream (tdata = {pad, best_score, best_id, rank}, tlast on the last
//  entry). s_tready is low while the readout runs, the list rotating one
//  cell per beat. Once the final beat is taken, the readout flag is set and
//  the first result then loads into the output register; s_tready returns
//  as the last result loads.
//  A stalled sink freezes the rotation; the output register holds its beat.
//  keep_count (APB, address 0) is clamped to 1..K_MAX; write it only idle.
//  Reset empties the list and sets keep_count to 16; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_similarity_select_top #(
	parameter int K_MAX = tksel_pkg::K_MAX_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	// candidate stream
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire [tksel_pkg::S_DATA_W-1:0]      s_tdata,   // node_id[63:0], score[79:64]
	input  wire [0:0]                          s_tuser,   // first[0]
	input  wire                                s_tlast,   // final_req
	// result stream
	output logic                               m_tvalid,
	input  wire                                m_tready,
	output logic [tksel_pkg::M_DATA_W-1:0]     m_tdata,   // rank[3:0], best_id[67:4],
	                                                      // best_score[83:68], zero[87:84]
	output logic                               m_tlast,   // last
	// configuration
	input  wire                                psel,
	input  wire                                penable,
	input  wire                                pwrite,
	input  wire [tksel_pkg::ADDR_W-1:0]        paddr,
	input  wire [tksel_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [tksel_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                               pready
);

	localparam int CW = $clog2(K_MAX+1);
	localparam int LW = (CW > tksel_pkg::KEEP_W) ? CW : tksel_pkg::KEEP_W;
	localparam int PAD_W = tksel_pkg::M_DATA_W - tksel_pkg::RANK_W - tksel_pkg::ID_W
		- tksel_pkg::SCORE_W;

	logic [tksel_pkg::KEEP_W-1:0] keep_count_q;
	logic [LW-1:0]                kc_ext;
	logic [CW-1:0]                lim;
	logic [CW-1:0]                count_q;
	logic [CW-1:0]                cnt_eff;
	logic [CW-1:0]                cnt_new;
	logic                         emit_q;
	logic [CW-1:0]                eidx_q;
	logic                         in_fire;
	logic                         out_load;
	logic                         emit_last;
	tksel_pkg::cell_ctrl_t        ctrl;

	logic [tksel_pkg::ID_W-1:0]           new_id;
	logic signed [tksel_pkg::SCORE_W-1:0] new_score;

	logic [tksel_pkg::ID_W-1:0]           id_w    [K_MAX];
	logic signed [tksel_pkg::SCORE_W-1:0] score_w [K_MAX];
	logic                                 cond_w  [K_MAX];

	logic                             m_tvalid_q;
	logic [tksel_pkg::M_DATA_W-1:0]   m_tdata_q;
	logic                             m_tlast_q;

	// config port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == tksel_pkg::REG_KEEP_COUNT)
		? tksel_pkg::CFG_DATA_W'(keep_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_count_q <= tksel_pkg::KEEP_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == tksel_pkg::REG_KEEP_COUNT) begin
			keep_count_q <= pwdata[tksel_pkg::KEEP_W-1:0];
		end
	end

	// effective limit, clamped to 1..K_MAX
	always_comb begin
		kc_ext = LW'(keep_count_q);
		if (kc_ext == '0) begin
			lim = CW'(1);
		end else if (kc_ext > LW'(K_MAX)) begin
			lim = CW'(K_MAX);
		end else begin
			lim = CW'(kc_ext);
		end
	end

	// input side
	assign s_tready  = !emit_q;
	assign in_fire   = s_tvalid && s_tready;
	assign new_id    = s_tdata[tksel_pkg::ID_W-1:0];
	assign new_score = s_tdata[tksel_pkg::ID_W +: tksel_pkg::SCORE_W];

	// entries present before this insert, and after it
	always_comb begin
		if (s_tuser[0]) begin
			cnt_eff = '0;
		end else if (count_q > lim) begin
			cnt_eff = lim;
		end else begin
			cnt_eff = count_q;
		end
		cnt_new = (cnt_eff < lim) ? cnt_eff + CW'(1) : cnt_eff;
	end

	// readout
	assign out_load  = emit_q && (!m_tvalid_q || m_tready);
	assign emit_last = (eidx_q + CW'(1)) == count_q;

	assign ctrl.ins_en = in_fire;
	assign ctrl.rot_en = out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			emit_q  <= 1'b0;
			eidx_q  <= '0;
		end else if (in_fire) begin
			count_q <= cnt_new;
			eidx_q  <= '0;
			emit_q  <= s_tlast;
		end else if (out_load) begin
			eidx_q <= eidx_q + CW'(1);
			if (emit_last) begin
				emit_q <= 1'b0;
			end
		end
	end

	// cell chain
	for (genvar i = 0; i < K_MAX; i++) begin : g_cell
		logic                                 pc;
		logic [tksel_pkg::ID_W-1:0]           pid;
		logic signed [tksel_pkg::SCORE_W-1:0] psc;
		logic [tksel_pkg::ID_W-1:0]           nid;
		logic signed [tksel_pkg::SCORE_W-1:0] nsc;

		if (i == 0) begin : g_head
			assign pc  = 1'b0;
			assign pid = new_id;
			assign psc = new_score;
		end else begin : g_body
			assign pc  = cond_w[i-1];
			assign pid = id_w[i-1];
			assign psc = score_w[i-1];
		end

		if (i == K_MAX - 1) begin : g_tail
			assign nid = id_w[0];
			assign nsc = score_w[0];
		end else begin : g_mid
			assign nid = id_w[i+1];
			assign nsc = score_w[i+1];
		end

		tksel_cell #(
			.K_MAX (K_MAX),
			.IDX   (i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.cnt        (cnt_eff),
			.rot_cnt    (count_q),
			.new_id     (new_id),
			.new_score  (new_score),
			.prev_cond  (pc),
			.prev_id    (pid),
			.prev_score (psc),
			.next_id    (nid),
			.next_score (nsc),
			.head_id    (id_w[0]),
			.head_score (score_w[0]),
			.cond       (cond_w[i]),
			.id         (id_w[i]),
			.score      (score_w[i])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {{PAD_W{1'b0}}, score_w[0], id_w[0],
				tksel_pkg::RANK_W'(eidx_q)};
			m_tlast_q <= emit_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

`default_nettype wire

// File: design/tksel_cell.sv
// ----------------------------------------------------------------------------
// tksel_cell
// One slot of the sorted candidate list. Compares the incoming score with its
// own, hands its entry down on insert and takes the entry of the slot below
// it (the last valid slot takes the head's) on readout rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module tksel_cell #(
	parameter int K_MAX = tksel_pkg::K_MAX_DEF,
	parameter int IDX   = 0
) (
	input  wire                                  clk,
	input  wire tksel_pkg::cell_ctrl_t           ctrl,
	input  wire [$clog2(K_MAX+1)-1:0]            cnt,        // valid entries for insert
	input  wire [$clog2(K_MAX+1)-1:0]            rot_cnt,    // entries in rotation
	input  wire [tksel_pkg::ID_W-1:0]            new_id,
	input  wire signed [tksel_pkg::SCORE_W-1:0]  new_score,
	input  wire                                  prev_cond,
	input  wire [tksel_pkg::ID_W-1:0]            prev_id,
	input  wire signed [tksel_pkg::SCORE_W-1:0]  prev_score,
	input  wire [tksel_pkg::ID_W-1:0]            next_id,
	input  wire signed [tksel_pkg::SCORE_W-1:0]  next_score,
	input  wire [tksel_pkg::ID_W-1:0]            head_id,
	input  wire signed [tksel_pkg::SCORE_W-1:0]  head_score,
	output logic                                 cond,
	output logic [tksel_pkg::ID_W-1:0]           id,
	output logic signed [tksel_pkg::SCORE_W-1:0] score
);

	localparam int CW = $clog2(K_MAX+1);
	localparam logic [CW-1:0] IDX_C  = CW'(IDX);
	localparam logic [CW-1:0] IDX_P1 = CW'(IDX + 1);

	logic [tksel_pkg::ID_W-1:0]           id_q;
	logic signed [tksel_pkg::SCORE_W-1:0] score_q;
	logic                                 take;

	// slot is free or beaten by the candidate
	assign cond = (IDX_C >= cnt) || (new_score > score_q);
	// first such slot is where the candidate lands
	assign take = cond && !prev_cond;

	always_ff @(posedge clk) begin
		if (ctrl.ins_en) begin
			if (take) begin
				id_q    <= new_id;
				score_q <= new_score;
			end else if (prev_cond) begin
				id_q    <= prev_id;
				score_q <= prev_score;
			end
		end else if (ctrl.rot_en) begin
			if (IDX_P1 < rot_cnt) begin
				id_q    <= next_id;
				score_q <= next_score;
			end else if (IDX_P1 == rot_cnt) begin
				id_q    <= head_id;
				score_q <= head_score;
			end
		end
	end

	assign id    = id_q;
	assign score = score_q;

endmodule

`default_nettype wire

// File: design/tksel_checker.sv
// ----------------------------------------------------------------------------
// tksel_checker
// Port-level checks for the top-K selector: stall hold, readout ordering,
// contiguity and input blocking during readout.
// ----------------------------------------------------------------------------
`default_nettype none

module tksel_checker (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              s_tvalid,
	input wire                              s_tready,
	input wire                              s_tlast,
	input wire                              m_tvalid,
	input wire                              m_tready,
	input wire [tksel_pkg::M_DATA_W-1:0]    m_tdata,
	input wire                              m_tlast
);

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result beat changed under stall");

	// a final request always starts a readout, which blocks input
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input taken right after a final request");

	// a fresh readout starts at rank zero
	a_rank0: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> m_tdata[tksel_pkg::RANK_W-1:0] == '0)
		else $error("readout did not start at rank zero");

	// readout beats follow without gaps and ranks count up
	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid
		&& m_tdata[tksel_pkg::RANK_W-1:0]
		== $past(m_tdata[tksel_pkg::RANK_W-1:0]) + tksel_pkg::RANK_W'(1))
		else $error("readout gap or rank out of order");

endmodule

bind top_k_similarity_select_top tksel_checker u_tksel_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire
